/* design/ssf_pkg.sv */
`default_nettype none
package ssf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [2:0] LARGE_START = 3'd7;
  localparam logic [2:0] SMALL_DIGITS = 3'd4;
  localparam logic [2:0] SMALL_LAST  = 3'd4;
  localparam logic [2:0] LARGE_LAST  = 3'd7;
  localparam logic [2:0] COMMA_BYTE_SMALL = 3'd4;
  localparam logic [2:0] COMMA_BYTE_LARGE = 3'd6;
  localparam logic [7:0] COMMA_BASE_SMALL = 8'h04;
  localparam logic [7:0] COMMA_BASE_LARGE = 8'h20;
  localparam logic [7:0] POINT_BIT = 8'h01;

  // One finished panel image
  typedef struct packed {
    logic            six_digit;
    logic [7:0][7:0] seg;
  } img_t;

  // Bit 7 set when the character has a glyph, bits 6:0 the segment code
  function automatic logic [7:0] glyph(input logic [7:0] ch);
    logic [7:0] up;
    logic [7:0] res;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      up = ch - 8'h20;
    end
    case (up)
      8'h20:   res = 8'h80;
      8'h2D:   res = 8'hC0;
      8'h30:   res = 8'hBF;
      8'h31:   res = 8'h86;
      8'h32:   res = 8'hDB;
      8'h33:   res = 8'hCF;
      8'h34:   res = 8'hE6;
      8'h35:   res = 8'hED;
      8'h36:   res = 8'hFD;
      8'h37:   res = 8'h87;
      8'h38:   res = 8'hFF;
      8'h39:   res = 8'hEF;
      8'h41:   res = 8'hF7;
      8'h42:   res = 8'hFC;
      8'h43:   res = 8'hB9;
      8'h44:   res = 8'hDE;
      8'h45:   res = 8'hF9;
      8'h46:   res = 8'hF1;
      8'h47:   res = 8'hEF;
      8'h48:   res = 8'hF6;
      8'h49:   res = 8'h86;
      8'h4A:   res = 8'h8E;
      8'h4C:   res = 8'hB8;
      8'h4E:   res = 8'hD4;
      8'h4F:   res = 8'hBF;
      8'h50:   res = 8'hF3;
      8'h53:   res = 8'hED;
      8'h54:   res = 8'hF8;
      8'h55:   res = 8'hBE;
      8'h59:   res = 8'hEE;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/ssf_front.sv */
`default_nettype none
module ssf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     char_code,
  input  wire logic           layout,
  input  wire logic           is_empty,
  input  wire logic           last_char,
  output ssf_pkg::img_t       img,
  output logic                img_push
);

  logic [7:0][7:0] store;
  logic [2:0]      digit_position;
  logic            latched_layout;
  logic            panel_full;
  logic            in_string;

  logic            start;
  logic            cur_large;
  logic [2:0]      cur_pos;
  logic            cur_full;
  logic [7:0][7:0] cur_store;
  logic [7:0][7:0] store_next;
  logic [7:0]      gl;
  logic            is_period;
  logic            is_comma;
  logic            we;
  logic [2:0]      widx;
  logic [7:0]      wbits;
  logic [2:0]      digit_position_next;
  logic            panel_full_next;
  logic            emit;

  always_comb begin
    start     = is_empty | ~in_string;
    cur_large = start ? layout : latched_layout;
    cur_pos   = start ? (layout ? ssf_pkg::LARGE_START : 3'd0) : digit_position;
    cur_full  = start ? 1'b0 : panel_full;
    cur_store = start ? '0 : store;
    gl        = ssf_pkg::glyph(char_code);
    is_period = (char_code == ssf_pkg::CH_PERIOD);
    is_comma  = (char_code == ssf_pkg::CH_COMMA);

    we                  = 1'b0;
    widx                = 3'd0;
    wbits               = 8'h00;
    digit_position_next = cur_pos;
    panel_full_next     = cur_full;

    if (!is_empty && !cur_full) begin
      if (!cur_large) begin
        if (is_period && cur_pos != 3'd0) begin
          we    = 1'b1;
          widx  = cur_pos;
          wbits = ssf_pkg::POINT_BIT;
        end else if (is_comma && cur_pos != 3'd0) begin
          we    = 1'b1;
          widx  = ssf_pkg::COMMA_BYTE_SMALL;
          wbits = ssf_pkg::COMMA_BASE_SMALL >> (cur_pos - 3'd1);
        end else if (gl[7]) begin
          digit_position_next = cur_pos + 3'd1;
          if (cur_pos >= ssf_pkg::SMALL_DIGITS) begin
            panel_full_next = 1'b1;
          end else begin
            we    = 1'b1;
            widx  = cur_pos;
            wbits = {gl[6:0], 1'b0};
          end
        end
      end else begin
        if (is_period && cur_pos != ssf_pkg::LARGE_START) begin
          // leftmost large digit has no byte for its point: drop
          if (cur_pos >= 3'd2) begin
            we    = 1'b1;
            widx  = cur_pos - 3'd2;
            wbits = ssf_pkg::POINT_BIT;
          end
        end else if (is_comma && cur_pos != ssf_pkg::LARGE_START) begin
          we    = 1'b1;
          widx  = ssf_pkg::COMMA_BYTE_LARGE;
          wbits = ssf_pkg::COMMA_BASE_LARGE << (3'd6 - cur_pos);
        end else if (gl[7]) begin
          if (cur_pos <= 3'd1) begin
            digit_position_next = 3'd0;
            panel_full_next     = 1'b1;
          end else begin
            digit_position_next = cur_pos - 3'd1;
            we    = 1'b1;
            widx  = cur_pos - 3'd2;
            wbits = {gl[6:0], 1'b0};
          end
        end
      end
    end

    for (int i = 0; i < 8; i++) begin
      store_next[i] = cur_store[i] | ((we && widx == 3'(i)) ? wbits : 8'h00);
    end

    emit          = is_empty | last_char;
    img_push      = accept & emit;
    img.six_digit = cur_large;
    img.seg       = store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_position <= 3'd0;
      latched_layout <= 1'b0;
      panel_full     <= 1'b0;
      in_string      <= 1'b0;
    end else if (accept) begin
      digit_position <= digit_position_next;
      latched_layout <= cur_large;
      panel_full     <= panel_full_next;
      in_string      <= ~emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store <= store_next;
    end
  end

endmodule
`default_nettype wire

/* design/ssf_fifo.sv */
`default_nettype none
module ssf_fifo #(
  parameter int DEPTH = ssf_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire ssf_pkg::img_t wdata,
  output logic               q_full,
  input  wire logic          rd,
  output ssf_pkg::img_t      rdata,
  output logic               q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssf_pkg::img_t entry [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign rdata   = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* design/ssf_back.sv */
`default_nettype none
module ssf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ssf_pkg::img_t head,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         seg_byte,
  output logic [2:0]         byte_index,
  output logic               last_byte
);

  logic [2:0] cnt;
  logic       take;

  always_comb begin
    empty      = q_empty;
    seg_byte   = head.seg[cnt];
    byte_index = cnt;
    last_byte  = (cnt == (head.six_digit ? ssf_pkg::LARGE_LAST : ssf_pkg::SMALL_LAST));
    take       = pop & ~q_empty;
    // release the image once its final byte leaves
    q_pop      = take & last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (take) begin
      cnt <= last_byte ? 3'd0 : cnt + 3'd1;
    end
  end

endmodule
`default_nettype wire

/* design/seven_segment_string_formatter.sv */
`default_nettype none
// Seven-segment string formatter. Feed a display string one character per
// transaction, rightmost character first, with last_char on the leftmost one
// (or is_empty for a blank string); the layout bit of a string's first
// character picks a 4-digit panel (5 segment bytes) or a 6-digit panel
// (8 bytes). A character is taken every cycle while the image queue is not
// full, with no gaps between strings. When a string ends, its finished image
// enters a queue of QUEUE_DEPTH images and its bytes appear on the result side
// one per cycle while pop is held, byte 0 first, from the cycle after the final
// character if no earlier image waits; full rises only while that image queue
// is full, which happens when strings end faster than their 5 or 8 bytes are popped.
module seven_segment_string_formatter #(
  parameter int QUEUE_DEPTH = ssf_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_code,
  input  wire logic       layout,
  input  wire logic       is_empty,
  input  wire logic       last_char,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      seg_byte,
  output logic [2:0]      byte_index,
  output logic            last_byte
);

  ssf_pkg::img_t img;
  ssf_pkg::img_t head;
  logic          img_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          accept;

  assign full   = q_full;
  assign accept = push & ~q_full;

  ssf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .layout    (layout),
    .is_empty  (is_empty),
    .last_char (last_char),
    .img       (img),
    .img_push  (img_push)
  );

  ssf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (img_push),
    .wdata   (img),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (head),
    .q_empty (q_empty)
  );

  ssf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .seg_byte   (seg_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

endmodule
`default_nettype wire

/* design/ssf_checker.sv */
`default_nettype none
module ssf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] seg_byte,
  input wire logic [2:0] byte_index,
  input wire logic       last_byte
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // bytes of one image leave in order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_byte) |=> (!empty && byte_index == $past(byte_index) + 3'd1))
    else $error("byte_index did not advance within an image");

  // the next image starts at byte 0
  a_index_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_byte) |=> (empty || byte_index == 3'd0))
    else $error("new image did not start at byte 0");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_byte) |-> (byte_index == 3'd4 || byte_index == 3'd7))
    else $error("last_byte on a wrong byte position");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(seg_byte) && $stable(byte_index)))
    else $error("waiting result changed before pop");

endmodule

bind seven_segment_string_formatter ssf_checker u_ssf_checker (.*);
`default_nettype wire

/* tb/segment_image_checker.sv */
`timescale 1ns / 1ps
module segment_image_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] char_code,
  input  wire logic       layout,
  input  wire logic       is_empty,
  input  wire logic       last_char,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [7:0] seg_byte,
  input  wire logic [2:0] byte_index,
  input  wire logic       last_byte,
  output int              errors,
  output int              pending,
  output int              bytes_checked,
  output int              images_built
);

  localparam logic [7:0] DOT_CHAR   = ".";
  localparam logic [7:0] COMMA_CHAR = ",";
  localparam logic [2:0] SMALL_MAX_DIGITS = 3'd4;
  localparam logic [2:0] LARGE_FIRST_POS  = 3'd7;
  localparam logic [2:0] SMALL_COMMA_SLOT = 3'd4;
  localparam logic [2:0] LARGE_COMMA_SLOT = 3'd6;
  localparam logic [7:0] SMALL_COMMA_MASK = 8'h04;
  localparam logic [7:0] LARGE_COMMA_MASK = 8'h20;
  localparam logic [7:0] DOT_MASK         = 8'h01;
  localparam int         SMALL_BYTES      = 5;
  localparam int         LARGE_BYTES      = 8;
  localparam int         PRINT_CAP        = 40;

  typedef struct packed {
    logic [7:0] seg;
    logic [2:0] idx;
    logic       last;
  } panel_byte_t;

  panel_byte_t expected_segments[$];

  logic [7:0] image [8];
  logic [2:0] digit_pos;
  logic       large_mode;
  logic       panel_done;
  logic       open_string;

  // Unshifted segment pattern of a character; known is low when it has none
  function automatic logic [6:0] segment_pattern(input logic [7:0] ch, output logic known);
    logic [7:0] u;
    logic [6:0] pat;
    u = ch;
    if (ch >= "a" && ch <= "z") begin
      u = ch - 8'd32;
    end
    known = 1'b1;
    case (u)
      " ": pat = 7'h00;
      "-": pat = 7'h40;
      "0", "O": pat = 7'h3F;
      "1", "I": pat = 7'h06;
      "2": pat = 7'h5B;
      "3": pat = 7'h4F;
      "4": pat = 7'h66;
      "5", "S": pat = 7'h6D;
      "6": pat = 7'h7D;
      "7": pat = 7'h07;
      "8": pat = 7'h7F;
      "9", "G": pat = 7'h6F;
      "A": pat = 7'h77;
      "B": pat = 7'h7C;
      "C": pat = 7'h39;
      "D": pat = 7'h5E;
      "E": pat = 7'h79;
      "F": pat = 7'h71;
      "H": pat = 7'h76;
      "J": pat = 7'h0E;
      "L": pat = 7'h38;
      "N": pat = 7'h54;
      "P": pat = 7'h73;
      "T": pat = 7'h78;
      "U": pat = 7'h3E;
      "Y": pat = 7'h6E;
      default: begin
        pat = 7'h00;
        known = 1'b0;
      end
    endcase
    return pat;
  endfunction

  // Small panel: digits count up from zero
  task place_small(input logic [7:0] ch);
    logic [6:0] pat;
    logic known;
    if (ch == DOT_CHAR && digit_pos != 0) begin
      image[digit_pos] |= DOT_MASK;
    end else if (ch == COMMA_CHAR && digit_pos != 0) begin
      image[SMALL_COMMA_SLOT] |= SMALL_COMMA_MASK >> (digit_pos - 3'd1);
    end else begin
      pat = segment_pattern(ch, known);
      if (known) begin
        digit_pos = digit_pos + 3'd1;
        if (digit_pos > SMALL_MAX_DIGITS) begin
          panel_done = 1'b1;
        end else begin
          image[digit_pos - 3'd1] |= {pat, 1'b0};
        end
      end
    end
  endtask

  // Large panel: digits count down from seven; comma bits above bit 7 drop out
  task place_large(input logic [7:0] ch);
    logic [6:0] pat;
    logic known;
    logic [7:0] mask;
    if (ch == DOT_CHAR && digit_pos < LARGE_FIRST_POS) begin
      if (digit_pos >= 3'd2) begin
        image[digit_pos - 3'd2] |= DOT_MASK;
      end
    end else if (ch == COMMA_CHAR && digit_pos < LARGE_FIRST_POS) begin
      mask = LARGE_COMMA_MASK << (3'd6 - digit_pos);
      image[LARGE_COMMA_SLOT] |= mask;
    end else begin
      pat = segment_pattern(ch, known);
      if (known) begin
        if (digit_pos <= 3'd1) begin
          digit_pos = 3'd0;
          panel_done = 1'b1;
        end else begin
          digit_pos = digit_pos - 3'd1;
          image[digit_pos - 3'd1] |= {pat, 1'b0};
        end
      end
    end
  endtask

  task absorb_char(input logic [7:0] ch, input logic lay, input logic blank,
                   input logic fin);
    int n;
    if (blank || !open_string) begin
      for (int k = 0; k < 8; k++) image[k] = 8'h00;
      large_mode = lay;
      digit_pos = lay ? LARGE_FIRST_POS : 3'd0;
      panel_done = 1'b0;
    end
    if (!blank && !panel_done) begin
      if (large_mode) place_large(ch);
      else place_small(ch);
    end
    if (blank || fin) begin
      open_string = 1'b0;
      n = large_mode ? LARGE_BYTES : SMALL_BYTES;
      for (int k = 0; k < n; k++) begin
        expected_segments.push_back('{seg: image[k], idx: k[2:0], last: (k == n - 1)});
      end
      images_built++;
    end else begin
      open_string = 1'b1;
    end
  endtask

  task report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    panel_byte_t want;
    if (rst) begin
      expected_segments.delete();
      for (int k = 0; k < 8; k++) image[k] = 8'h00;
      digit_pos = 3'd0;
      large_mode = 1'b0;
      panel_done = 1'b0;
      open_string = 1'b0;
      errors = 0;
      bytes_checked = 0;
      images_built = 0;
      pending <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_segments.size() == 0) begin
          report_mismatch("unexpected byte, index", int'(byte_index), 0);
        end else begin
          want = expected_segments.pop_front();
          if (seg_byte !== want.seg) begin
            report_mismatch("seg_byte", int'(seg_byte), int'(want.seg));
          end
          if (byte_index !== want.idx) begin
            report_mismatch("byte_index", int'(byte_index), int'(want.idx));
          end
          if (last_byte !== want.last) begin
            report_mismatch("last_byte", int'(last_byte), int'(want.last));
          end
          bytes_checked++;
        end
      end
      if (push && !full) begin
        absorb_char(char_code, layout, is_empty, last_char);
      end
      pending <= expected_segments.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 95;
  localparam int DRAIN_CYCLES   = 20;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] char_code;
  logic       layout;
  logic       is_empty;
  logic       last_char;
  logic       empty;
  logic       pop;
  logic [7:0] seg_byte;
  logic [2:0] byte_index;
  logic       last_byte;

  int errors;
  int pending;
  int bytes_checked;
  int images_built;

  int idle_pct;
  int stall_pct;
  int items_sent;
  int phase_goal;
  int full_cycles;
  int quiet_cycles;
  logic hold_request;

  seven_segment_string_formatter uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_code  (char_code),
    .layout     (layout),
    .is_empty   (is_empty),
    .last_char  (last_char),
    .empty      (empty),
    .pop        (pop),
    .seg_byte   (seg_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

  segment_image_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_code     (char_code),
    .layout        (layout),
    .is_empty      (is_empty),
    .last_char     (last_char),
    .empty         (empty),
    .pop           (pop),
    .seg_byte      (seg_byte),
    .byte_index    (byte_index),
    .last_byte     (last_byte),
    .errors        (errors),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .images_built  (images_built)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one character and hold it until the transaction completes
  task automatic send_char(input logic [7:0] ch, input logic lay, input logic blank,
                           input logic fin);
    push <= 1'b1;
    char_code <= ch;
    layout <= lay;
    is_empty <= blank;
    last_char <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      char_code <= 8'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 8'("0" + $urandom_range(0, 9));
    if (pick < 70) return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
    if (pick < 80) return ".";
    if (pick < 90) return ",";
    if (pick < 95) return $urandom_range(0, 1) ? " " : "-";
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_string();
    int len;
    logic lay;
    lay = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 8) begin
      send_char(8'($urandom), lay, 1'b1, 1'($urandom_range(0, 1)));
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      // An empty mark mid-string restarts from scratch
      if (k > 0 && $urandom_range(0, 99) < 3) begin
        send_char(8'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                  1'($urandom_range(0, 1)));
      end else begin
        send_char(random_char(), (k == 0) ? lay : 1'($urandom_range(0, 1)), 1'b0,
                  k == len - 1);
      end
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
      full_cycles <= 0;
    end else begin
      if (push && full) full_cycles <= full_cycles + 1;
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d bytes pending",
                 quiet_cycles, pending);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    hold_request = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    phase_goal = 0;
    rst <= 1'b1;
    push <= 1'b0;
    char_code <= 8'h00;
    layout <= 1'b0;
    is_empty <= 1'b0;
    last_char <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Blank strings on both panels
    send_char(8'h00, 1'b0, 1'b1, 1'b0);
    send_char(8'hFF, 1'b1, 1'b1, 1'b1);

    // Small panel: leading dot, dot and comma marks, unknown byte, overflow
    send_char(".", 1'b0, 1'b0, 1'b0);
    send_char("0", 1'b0, 1'b0, 1'b0);
    send_char(".", 1'b1, 1'b0, 1'b0);
    send_char(",", 1'b0, 1'b0, 1'b0);
    send_char("a", 1'b1, 1'b0, 1'b0);
    send_char(" ", 1'b0, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0, 1'b0);
    send_char("9", 1'b0, 1'b0, 1'b0);
    send_char(",", 1'b0, 1'b0, 1'b0);
    send_char("5", 1'b0, 1'b0, 1'b0);
    send_char("1", 1'b0, 1'b0, 1'b1);

    // Large panel: dot at the leftmost digit, comma shifted out, full panel
    send_char(",", 1'b1, 1'b0, 1'b0);
    send_char("H", 1'b0, 1'b0, 1'b0);
    send_char(".", 1'b0, 1'b0, 1'b0);
    send_char(",", 1'b1, 1'b0, 1'b0);
    send_char("e", 1'b0, 1'b0, 1'b0);
    send_char("L", 1'b0, 1'b0, 1'b0);
    send_char("p", 1'b0, 1'b0, 1'b0);
    send_char("1", 1'b0, 1'b0, 1'b0);
    send_char("2", 1'b0, 1'b0, 1'b0);
    send_char(".", 1'b0, 1'b0, 1'b0);
    send_char(",", 1'b0, 1'b0, 1'b0);
    send_char("3", 1'b0, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0, 1'b1);
    wait_drained();

    // Block the result side and keep ending strings until input backs up
    hold_request = 1'b1;
    repeat (16) send_char(random_char(), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) send_random_string();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d characters forming %0d panel images, checked %0d segment bytes",
             items_sent, images_built, bytes_checked);
    $display("input backed up by a full image queue for %0d cycles", full_cycles);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
